// ===== design/spq_pkg.sv =====
package spq_pkg;

  // Number of slots in the queue.
  localparam int QUEUE_DEPTH = 16;
  // Width of the entry count, wide enough to hold QUEUE_DEPTH itself.
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W       = 5;
  localparam int PRIO_W      = 8;
  localparam int HANDLE_W    = 8;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 24;

  // Action codes carried on in_tuser.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } spq_op_t;

  // Command broadcast to every cell.
  typedef struct packed {
    spq_op_t             op;
    logic [PRIO_W-1:0]   prio;
    logic [HANDLE_W-1:0] handle;
  } spq_cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                gt;
    logic [PRIO_W-1:0]   prio;
    logic [HANDLE_W-1:0] handle;
  } spq_link_t;

endpackage

// ===== design/sorted_priority_queue.sv =====
// Sorted priority queue of task handles, built as a row of compare-and-shift cells.
// The result of a request is registered and appears in the cycle after it is accepted.
// Throughput: one request per cycle while the output is not stalled; every cell compares and shifts in parallel,
// and the output register is the only stage between the two channels.
// Reset (rst_n low, synchronous): entry count and output valid clear; slot
// contents are left as they are and become valid only once written.
module sorted_priority_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input requests.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [spq_pkg::IN_DATA_W-1:0]  in_tdata,  // task_handle[7:0], priority_req[15:8]
  input  logic                           in_tuser,  // action (0 insert, 1 pop)
  // Results.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [spq_pkg::OUT_DATA_W-1:0] out_tdata  // status[1:0], popped_valid[2],
                                                    // popped_handle[10:3],
                                                    // popped_priority[18:11],
                                                    // occupancy[23:19]
);
  import spq_pkg::*;

  logic                in_accept;
  logic [HANDLE_W-1:0] in_handle;
  logic [PRIO_W-1:0]   in_prio;
  logic                full;
  logic                empty;
  spq_cmd_t            cmd;

  logic [CNT_W-1:0]    count_r, count_nxt;

  spq_link_t           cell_link [QUEUE_DEPTH];
  logic                cell_valid [QUEUE_DEPTH];
  spq_link_t           edge_link;

  // Output register.
  logic                out_valid_r,  out_valid_nxt;
  spq_status_t         status_r,     status_nxt;
  logic                pvalid_r,     pvalid_nxt;
  logic [HANDLE_W-1:0] phandle_r,    phandle_nxt;
  logic [PRIO_W-1:0]   pprio_r,      pprio_nxt;
  logic [OCC_W-1:0]    occ_r,        occ_nxt;

  assign in_handle = in_tdata[HANDLE_W-1:0];
  assign in_prio   = in_tdata[HANDLE_W +: PRIO_W];

  // Accept a new request whenever the output slot is free or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);

  // Build the command for the cell row; drop inserts when full, pops when empty.
  always_comb begin
    cmd.op     = OP_NONE;
    cmd.prio   = in_prio;
    cmd.handle = in_handle;
    if (in_accept) begin
      if (in_tuser == ACT_POP) begin
        if (!empty) cmd.op = OP_POP;
      end else begin
        if (!full) cmd.op = OP_INSERT;
      end
    end
  end

  // Cells beyond either end see nothing to shift in.
  assign edge_link = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign cell_valid[i] = (CNT_W'(i) < count_r);
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk   (clk),
        .cmd   (cmd),
        .valid (cell_valid[i]),
        .left  (edge_link),
        .right (cell_link[i+1]),
        .self  (cell_link[i])
      );
    end else if (i == QUEUE_DEPTH - 1) begin : g_tail
      spq_cell u_cell (
        .clk   (clk),
        .cmd   (cmd),
        .valid (cell_valid[i]),
        .left  (cell_link[i-1]),
        .right (edge_link),
        .self  (cell_link[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk   (clk),
        .cmd   (cmd),
        .valid (cell_valid[i]),
        .left  (cell_link[i-1]),
        .right (cell_link[i+1]),
        .self  (cell_link[i])
      );
    end
  end

  // Entry count tracks the committed operation.
  always_comb begin
    count_nxt = count_r;
    unique case (cmd.op)
      OP_INSERT: count_nxt = count_r + CNT_W'(1);
      OP_POP:    count_nxt = count_r - CNT_W'(1);
      default:   count_nxt = count_r;
    endcase
  end

  // Result of the accepted request; the head cell supplies the popped entry.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    pvalid_nxt    = pvalid_r;
    phandle_nxt   = phandle_r;
    pprio_nxt     = pprio_r;
    occ_nxt       = occ_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      pvalid_nxt    = 1'b0;
      phandle_nxt   = '0;
      pprio_nxt     = '0;
      occ_nxt       = OCC_W'(count_nxt);
      if (in_tuser == ACT_POP) begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          pvalid_nxt  = 1'b1;
          phandle_nxt = cell_link[0].handle;
          pprio_nxt   = cell_link[0].prio;
        end
      end else if (full) begin
        status_nxt = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload until it is taken.
  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    pvalid_r  <= pvalid_nxt;
    phandle_r <= phandle_nxt;
    pprio_r   <= pprio_nxt;
    occ_r     <= occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {occ_r, pprio_r, phandle_r, pvalid_r, status_r};

endmodule

// ===== design/spq_cell.sv =====
module spq_cell (
  input  logic              clk,
  input  spq_pkg::spq_cmd_t  cmd,
  input  logic              valid,
  input  spq_pkg::spq_link_t left,
  input  spq_pkg::spq_link_t right,
  output spq_pkg::spq_link_t self
);
  import spq_pkg::*;

  logic [PRIO_W-1:0]   prio_r,   prio_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic                gt;

  // Held entry is strictly less urgent than the incoming one.
  assign gt = valid && (prio_r > cmd.prio);

  assign self.gt     = gt;
  assign self.prio   = prio_r;
  assign self.handle = handle_r;

  always_comb begin
    prio_nxt   = prio_r;
    handle_nxt = handle_r;
    unique case (cmd.op)
      OP_INSERT: begin
        // Shift right behind the new entry, or take the new entry here.
        priority if (left.gt) begin
          prio_nxt   = left.prio;
          handle_nxt = left.handle;
        end else if (!valid || gt) begin
          prio_nxt   = cmd.prio;
          handle_nxt = cmd.handle;
        end else begin
          // Hold an entry that stays ahead of the new one.
          prio_nxt   = prio_r;
          handle_nxt = handle_r;
        end
      end
      OP_POP: begin
        prio_nxt   = right.prio;
        handle_nxt = right.handle;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prio_r   <= prio_nxt;
    handle_r <= handle_nxt;
  end

endmodule

// ===== design/spq_checker.sv =====
module spq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [spq_pkg::OUT_DATA_W-1:0] out_tdata
);
  import spq_pkg::*;

  logic [STATUS_W-1:0] st;
  logic                pv;
  logic [OCC_W-1:0]    occ;

  assign st  = out_tdata[STATUS_W-1:0];
  assign pv  = out_tdata[STATUS_W];
  assign occ = out_tdata[OUT_DATA_W-1 -: OCC_W];

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Every accepted request yields a result in the next cycle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted request produced no result");

  // A dropped insert reports a full queue.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_FULL |-> occ == OCC_W'(QUEUE_DEPTH) && !pv)
    else $error("full status with wrong occupancy");

  // A pop on empty reports nothing popped and an empty queue.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_EMPTY |-> occ == '0 && !pv
    && out_tdata[OUT_DATA_W-OCC_W-1:STATUS_W+1] == '0)
    else $error("empty status with popped data");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/sorted_priority_queue_tb.sv =====
module sorted_priority_queue_tb;
  import spq_pkg::*;

  // One result as it leaves the queue; field order matches out_tdata from the top bit down.
  typedef struct packed {
    logic [OCC_W-1:0]    occupancy;
    logic [PRIO_W-1:0]   popped_priority;
    logic [HANDLE_W-1:0] popped_handle;
    logic                popped_valid;
    logic [STATUS_W-1:0] status;
  } queue_result_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    logic                act;
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
    logic                typed;
    queue_result_t       want;
  } directed_req_t;

  localparam int DIRECTED_N = 25;
  localparam int RANDOM_N   = 1250;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // task_handle[7:0], priority_req[15:8]
  logic                  in_tuser   = ACT_INSERT;  // action (0 insert, 1 pop)
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // status[1:0], popped_valid[2], popped_handle[10:3],
                                     // popped_priority[18:11], occupancy[23:19]

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          err_cnt       = 0;

  // Shadow copy of the queue contents, kept in priority order.
  logic [PRIO_W-1:0]   shadow_prio   [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] shadow_handle [QUEUE_DEPTH];
  int                  shadow_count = 0;

  // Results still owed by the block, oldest first.
  queue_result_t pending_results[$];

  directed_req_t directed_tab [DIRECTED_N];

  sorted_priority_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Apply one request to the shadow queue and return the result it must produce.
  function automatic queue_result_t advance_queue(input logic act,
                                                  input logic [HANDLE_W-1:0] handle,
                                                  input logic [PRIO_W-1:0] prio);
    queue_result_t res;
    int pos;
    res = '0;
    if (act == ACT_INSERT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // Slide every strictly less urgent entry back one slot; ties stay ahead.
        pos = shadow_count;
        while (pos > 0 && shadow_prio[pos-1] > prio) begin
          shadow_prio[pos]   = shadow_prio[pos-1];
          shadow_handle[pos] = shadow_handle[pos-1];
          pos--;
        end
        shadow_prio[pos]   = prio;
        shadow_handle[pos] = handle;
        shadow_count++;
        res.status = ST_OK;
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.status          = ST_OK;
      res.popped_valid    = 1'b1;
      res.popped_handle   = shadow_handle[0];
      res.popped_priority = shadow_prio[0];
      for (int k = 1; k < shadow_count; k++) begin
        shadow_prio[k-1]   = shadow_prio[k];
        shadow_handle[k-1] = shadow_handle[k];
      end
      shadow_count--;
    end
    res.occupancy = shadow_count[OCC_W-1:0];
    return res;
  endfunction

  function automatic directed_req_t make_row(input logic act, input logic [7:0] handle,
                                             input logic [7:0] prio, input int typed,
                                             input logic [1:0] st, input int vld,
                                             input logic [7:0] ph, input logic [7:0] pp,
                                             input logic [4:0] occ);
    directed_req_t row;
    row.act                  = act;
    row.handle               = handle;
    row.prio                 = prio;
    row.typed                = (typed != 0);
    row.want.status          = st;
    row.want.popped_valid    = (vld != 0);
    row.want.popped_handle   = ph;
    row.want.popped_priority = pp;
    row.want.occupancy       = occ;
    return row;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Compare one accepted result against the oldest owed one.
  task automatic check_result(input queue_result_t got);
    queue_result_t want;
    if (pending_results.size() == 0) begin
      $error("result with no request pending: %h", got);
      err_cnt++;
    end else begin
      want = pending_results.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("popped_valid", 32'(want.popped_valid), 32'(got.popped_valid));
      check_field("popped_handle", 32'(want.popped_handle), 32'(got.popped_handle));
      check_field("popped_priority", 32'(want.popped_priority),
                  32'(got.popped_priority));
      check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
    end
  endtask

  // Present one request, idling first at the current rate, and hold it until accepted.
  // Leave in_tvalid high afterwards so a following request goes out back to back.
  task automatic send_request(input logic act, input logic [HANDLE_W-1:0] handle,
                              input logic [PRIO_W-1:0] prio);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {prio, handle};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: check what was accepted at this edge, then pick the next ready value.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) check_result(out_tdata);
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    queue_result_t predicted;
    logic          act;
    logic [7:0]    handle;
    logic [7:0]    prio;
    int            n_sent;
    int            burst_len;
    int            insert_pct;
    int            prio_mode;

    // Directed part: pop from empty, field extremes, ties at both ends of the
    // priority range, fill to the top, insert into a full queue, then drain a few.
    directed_tab[0]  = make_row(ACT_POP,    8'h00, 8'h00, 1, ST_EMPTY, 0, 8'h00, 8'h00, 5'd0);
    directed_tab[1]  = make_row(ACT_INSERT, 8'hA5, 8'h80, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[2]  = make_row(ACT_INSERT, 8'hFF, 8'hFF, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[3]  = make_row(ACT_INSERT, 8'h00, 8'h00, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[4]  = make_row(ACT_INSERT, 8'h11, 8'h80, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[5]  = make_row(ACT_POP,    8'hFF, 8'hFF, 1, ST_OK,    1, 8'h00, 8'h00, 5'd3);
    directed_tab[6]  = make_row(ACT_INSERT, 8'h5A, 8'h7F, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[7]  = make_row(ACT_INSERT, 8'h01, 8'hFF, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[8]  = make_row(ACT_INSERT, 8'h3C, 8'h00, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[9]  = make_row(ACT_INSERT, 8'hC3, 8'h00, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[10] = make_row(ACT_INSERT, 8'h80, 8'h01, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[11] = make_row(ACT_INSERT, 8'h7F, 8'hFE, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[12] = make_row(ACT_INSERT, 8'h55, 8'h80, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[13] = make_row(ACT_INSERT, 8'hAA, 8'h55, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[14] = make_row(ACT_INSERT, 8'h0F, 8'hAA, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[15] = make_row(ACT_INSERT, 8'hF0, 8'h0F, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[16] = make_row(ACT_INSERT, 8'h02, 8'hF0, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[17] = make_row(ACT_INSERT, 8'hFE, 8'h40, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[18] = make_row(ACT_INSERT, 8'h99, 8'h7F, 0, ST_OK,    0, 8'h00, 8'h00, 5'd0);
    directed_tab[19] = make_row(ACT_INSERT, 8'h66, 8'h00, 1, ST_FULL,  0, 8'h00, 8'h00, 5'd16);
    for (int i = 20; i < DIRECTED_N; i++)
      directed_tab[i] = make_row(ACT_POP, 8'h00, 8'h00, 0, ST_OK, 0, 8'h00, 8'h00, 5'd0);

    // Hold reset, then release it once.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 9;
    recv_idle_pct = 73;
    for (int i = 0; i < DIRECTED_N; i++) begin
      send_request(directed_tab[i].act, directed_tab[i].handle, directed_tab[i].prio);
      predicted = advance_queue(directed_tab[i].act, directed_tab[i].handle,
                                directed_tab[i].prio);
      pending_results.push_back(directed_tab[i].typed ? directed_tab[i].want : predicted);
    end

    // Random part in three idling phases: sender lightly and receiver heavily,
    // then the reverse, then neither. Drain between phases so the sender also
    // sits fully paused with the queue quiet at least once.
    n_sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 73 : 0;
      recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 9 : 0;
      while (n_sent < (phase + 1) * RANDOM_N / 3) begin
        // Bursts lean toward filling, draining or churning so the queue
        // swings between empty and full; priority spread sets how many ties occur.
        burst_len  = $urandom_range(4, 40);
        insert_pct = ($urandom_range(0, 2) == 0) ? 85 : ($urandom_range(0, 1) ? 15 : 50);
        prio_mode  = $urandom_range(0, 3);
        for (int k = 0; k < burst_len; k++) begin
          act    = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_POP;
          handle = 8'($urandom);
          case (prio_mode)
            0: prio = 8'($urandom);
            1: prio = 8'($urandom_range(0, 3));
            2: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: prio = 8'($urandom_range(100, 110));
          endcase
          send_request(act, handle, prio);
          pending_results.push_back(advance_queue(act, handle, prio));
          n_sent++;
        end
      end
    end

    // Wait out every owed result, then keep clocking to catch strays.
    drain_results();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Stop a hung run well past the slowest legal finish.
  initial begin
    #(12 * 400000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sorted_priority_queue.f =====
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
design/spq_checker.sv
sim/sorted_priority_queue_tb.sv
